// File: rtl/flap_band_select_by_mass_speed_defines.svh
// assertion macros for the flap band selector
`ifndef FLAP_BAND_SELECT_BY_MASS_SPEED_DEFINES_SVH
`define FLAP_BAND_SELECT_BY_MASS_SPEED_DEFINES_SVH
`ifndef SYNTHESIS
`define FBS_CHECK(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("fbs check failed");
`define FBS_CHECK_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("fbs check failed");
`else
`define FBS_CHECK(label, pre, post)
`define FBS_CHECK_NEXT(label, pre, post)
`endif
`endif

// File: rtl/fbs_pkg.sv
`default_nettype none
package fbs_pkg;

  localparam int SPEED_W  = 16;
  localparam int WEIGHT_W = 12;
  localparam int FRAC_W   = 17;
  localparam int FLAP_W   = 5;

  // no range / no flap markers
  localparam logic signed [SPEED_W-1:0] NO_SPEED = -16'sd16;
  localparam logic signed [FLAP_W-1:0]  NO_FLAP  = -5'sd1;

  typedef enum logic [1:0] {
    FUNC_WEIGHT = 2'd0,
    FUNC_RANGE  = 2'd1,
    FUNC_BEST   = 2'd2,
    FUNC_LIST   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_WEIGHT_COUNT  = 3'd0,
    REG_BAND_COUNT    = 3'd1,
    REG_LOWSPEED_MIN  = 3'd2,
    REG_LOWSPEED_MAX  = 3'd3,
    REG_LOWSPEED_FLAP = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic                      present;
    logic signed [SPEED_W-1:0] vmin;
    logic signed [SPEED_W-1:0] vmax;
  } range_cell_t;

endpackage
`default_nettype wire

// File: rtl/fbs_frac_div.sv
`default_nettype none
// restoring divider: frac = floor(num * 65536 / den), num <= den, one bit per cycle
module fbs_frac_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fbs_pkg::SPEED_W-1:0]   num,
  input  logic [fbs_pkg::SPEED_W-1:0]   den,
  output logic                          busy,
  output logic [fbs_pkg::FRAC_W-1:0]    frac
);
  import fbs_pkg::*;

  logic [SPEED_W-1:0] rem;
  logic [SPEED_W-1:0] den_q;
  logic [4:0]         cnt;
  logic [SPEED_W:0]   rem2;
  logic               take;
  logic               num_ge;

  assign rem2   = {rem, 1'b0};
  assign take   = rem2 >= {1'b0, den_q};
  assign num_ge = num >= den;

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'd16;
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  // remainder and quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      den_q <= den;
      rem   <= num_ge ? (num - den) : num;
      frac  <= {{(FRAC_W-1){1'b0}}, num_ge};
    end else if (busy) begin
      rem  <= take ? SPEED_W'(rem2 - {1'b0, den_q}) : rem2[SPEED_W-1:0];
      frac <= {frac[FRAC_W-2:0], take};
    end
  end

endmodule
`default_nettype wire

// File: rtl/flap_band_select_by_mass_speed.sv
`default_nettype none
// channel   | direction | handshake               | payload
// config    | in/out    | psel penable pwrite     | paddr pwdata prdata
// command   | in        | cmd_valid / cmd_stall   | func, table fields, mass, speed
// response  | out       | rsp_valid / rsp_stall   | band_index range_min range_max last
//
// table writes complete on acceptance; a query scans up to n weights one per cycle
// over the single weight memory read port, runs the divider when needed for a 17-bit
// fraction, then does two range memory reads and up to two shared multiplies per band
// reset clears control and config; the tables hold garbage until written
// command side is stalled while a query runs; response stalls hold the query
module flap_band_select_by_mass_speed #(
  parameter int MAX_WEIGHTS = 16,
  parameter int MAX_BANDS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  func,
  input  logic [3:0]  table_band,
  input  logic [3:0]  table_weight_slot,
  input  logic [fbs_pkg::WEIGHT_W-1:0]       weight_value,
  input  logic signed [fbs_pkg::SPEED_W-1:0] entry_min,
  input  logic signed [fbs_pkg::SPEED_W-1:0] entry_max,
  input  logic        entry_present,
  input  logic [15:0] mass,
  input  logic [14:0] speed,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic signed [fbs_pkg::FLAP_W-1:0]  band_index,
  output logic signed [fbs_pkg::SPEED_W-1:0] range_min,
  output logic signed [fbs_pkg::SPEED_W-1:0] range_max,
  output logic        last
);
  import fbs_pkg::*;

  localparam int WAW    = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;
  localparam int NW     = $clog2(MAX_WEIGHTS + 1);
  localparam int NBW    = $clog2(MAX_BANDS + 1);
  localparam int RDEPTH = MAX_BANDS * MAX_WEIGHTS;
  localparam int RAW    = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_FIRST = 13'b0000000000010,
    S_LASTW = 13'b0000000000100,
    S_SCAN  = 13'b0000000001000,
    S_DIV   = 13'b0000000010000,
    S_RA    = 13'b0000000100000,
    S_RB    = 13'b0000001000000,
    S_EVAL  = 13'b0000010000000,
    S_LERP1 = 13'b0000100000000,
    S_LERP2 = 13'b0001000000000,
    S_CHECK = 13'b0010000000000,
    S_NEXT  = 13'b0100000000000,
    S_FINAL = 13'b1000000000000
  } state_t;

  state_t state;

  // config registers
  logic [4:0]                weight_count;
  logic [4:0]                band_count;
  logic signed [SPEED_W-1:0] lowspeed_min;
  logic signed [SPEED_W-1:0] lowspeed_max;
  logic signed [FLAP_W-1:0]  lowspeed_flap;
  logic                      cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_count  <= '0;
      band_count    <= '0;
      lowspeed_min  <= NO_SPEED;
      lowspeed_max  <= NO_SPEED;
      lowspeed_flap <= NO_FLAP;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(paddr[4:2]))
        REG_WEIGHT_COUNT:  weight_count  <= pwdata[4:0];
        REG_BAND_COUNT:    band_count    <= pwdata[4:0];
        REG_LOWSPEED_MIN:  lowspeed_min  <= pwdata[15:0];
        REG_LOWSPEED_MAX:  lowspeed_max  <= pwdata[15:0];
        REG_LOWSPEED_FLAP: lowspeed_flap <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      REG_WEIGHT_COUNT:  prdata = {27'd0, weight_count};
      REG_BAND_COUNT:    prdata = {27'd0, band_count};
      REG_LOWSPEED_MIN:  prdata = {{16{lowspeed_min[15]}}, lowspeed_min};
      REG_LOWSPEED_MAX:  prdata = {{16{lowspeed_max[15]}}, lowspeed_max};
      REG_LOWSPEED_FLAP: prdata = {{27{lowspeed_flap[4]}}, lowspeed_flap};
      default:           prdata = '0;
    endcase
  end

  // saturated counts
  logic [NW-1:0]  n_used;
  logic [NBW-1:0] nb_used;

  assign n_used  = (32'(weight_count) > MAX_WEIGHTS) ? NW'(MAX_WEIGHTS) : NW'(weight_count);
  assign nb_used = (32'(band_count) > MAX_BANDS) ? NBW'(MAX_BANDS) : NBW'(band_count);

  logic  cmd_accept;
  func_t cmd_func;

  assign cmd_stall  = (state != S_IDLE);
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign cmd_func   = func_t'(func);

  // query registers
  func_t                     func_q;
  logic [15:0]               mass_q;
  logic signed [SPEED_W-1:0] speed_q;
  logic [WAW-1:0]            j;
  logic [WEIGHT_W-1:0]       prev_w;
  logic [WAW-1:0]            slot_a;
  logic [WAW-1:0]            slot_b;
  logic [FRAC_W-1:0]         frac;
  logic [NBW-1:0]            bi;
  range_cell_t               c1;
  range_cell_t               c2;
  logic signed [34:0]        prod;
  logic signed [SPEED_W-1:0] cur_lo;
  logic signed [SPEED_W-1:0] cur_hi;
  logic                      have_pend;
  logic signed [FLAP_W-1:0]  pend_band;
  logic signed [SPEED_W-1:0] pend_lo;
  logic signed [SPEED_W-1:0] pend_hi;

  // weight memory
  logic [WEIGHT_W-1:0] wmem [MAX_WEIGHTS];
  logic [WEIGHT_W-1:0] w_rd;
  logic [WAW-1:0]      w_raddr;
  logic                w_we;

  assign w_we = cmd_accept && (cmd_func == FUNC_WEIGHT) &&
                (32'(table_weight_slot) < MAX_WEIGHTS);

  always_comb begin
    priority case (state)
      S_FIRST: w_raddr = WAW'(n_used - NW'(1));
      S_SCAN:  w_raddr = j + WAW'(1);
      default: w_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[WAW'(table_weight_slot)] <= weight_value;
    end
    w_rd <= wmem[w_raddr];
  end

  // range memory, row per band
  range_cell_t     rmem [RDEPTH];
  range_cell_t     r_rd;
  range_cell_t     r_wdata;
  logic [RAW-1:0]  r_raddr;
  logic [RAW-1:0]  r_waddr;
  logic            r_we;

  assign r_we    = cmd_accept && (cmd_func == FUNC_RANGE) &&
                   (32'(table_band) < MAX_BANDS) && (32'(table_weight_slot) < MAX_WEIGHTS);
  assign r_waddr = RAW'(32'(table_band) * MAX_WEIGHTS + 32'(table_weight_slot));
  assign r_raddr = RAW'(32'(bi) * MAX_WEIGHTS +
                        32'((state == S_RB) ? slot_b : slot_a));
  assign r_wdata = '{present: entry_present, vmin: entry_min, vmax: entry_max};

  always_ff @(posedge clk) begin
    if (r_we) begin
      rmem[r_waddr] <= r_wdata;
    end
    r_rd <= rmem[r_raddr];
  end

  // low-speed window
  logic win_on;
  logic signed [SPEED_W-1:0] speed_s;

  assign speed_s = $signed({1'b0, speed});
  assign win_on  = !lowspeed_min[SPEED_W-1] && !lowspeed_max[SPEED_W-1] &&
                   (speed_s >= lowspeed_min) && (speed_s <= lowspeed_max);

  // bracket scan compare
  logic [15:0] lo16;
  logic [15:0] cur16;
  logic        scan_hit;
  logic [15:0] span;
  logic [15:0] dnum;

  assign lo16     = {prev_w, 4'd0};
  assign cur16    = {w_rd, 4'd0};
  assign scan_hit = (j != '0) && (lo16 <= mass_q) && (mass_q <= cur16);
  assign span     = cur16 - lo16;
  assign dnum     = mass_q - lo16;

  logic              div_start;
  logic              div_busy;
  logic [FRAC_W-1:0] div_frac;

  assign div_start = (state == S_SCAN) && scan_hit && (span != '0);

  fbs_frac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (dnum),
    .den   (span),
    .busy  (div_busy),
    .frac  (div_frac)
  );

  // shared interpolation multiplier
  logic signed [SPEED_W:0] mul_diff;
  logic signed [34:0]      lerp_sum;
  logic signed [SPEED_W-1:0] lerp_adj;
  logic c1_span;
  logic c2_span;

  assign mul_diff = (state == S_EVAL)
                  ? ($signed({r_rd.vmin[15], r_rd.vmin}) - $signed({c1.vmin[15], c1.vmin}))
                  : ($signed({c2.vmax[15], c2.vmax}) - $signed({c1.vmax[15], c1.vmax}));
  assign lerp_sum = prod + 35'sd32768;
  assign lerp_adj = lerp_sum[31:16];
  assign c1_span  = !c1.vmin[15] && !c1.vmax[15];
  assign c2_span  = !r_rd.vmin[15] && !r_rd.vmax[15];

  logic out_free;
  logic in_range;
  logic rsp_load;

  assign out_free = !rsp_valid || !rsp_stall;
  assign in_range = (speed_q >= cur_lo) && (speed_q <= cur_hi);
  assign rsp_load = out_free &&
                    ((state == S_FINAL) ||
                     ((state == S_CHECK) && (func_q != FUNC_BEST) && have_pend));

  // response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // query sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      have_pend <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          have_pend <= 1'b0;
          bi        <= '0;
          if (cmd_accept) begin
            func_q  <= cmd_func;
            mass_q  <= mass;
            speed_q <= speed_s;
            unique case (cmd_func)
              FUNC_WEIGHT, FUNC_RANGE: ;
              FUNC_BEST: begin
                pend_lo <= NO_SPEED;
                pend_hi <= NO_SPEED;
                if (win_on) begin
                  pend_band <= lowspeed_flap;
                  state     <= S_FINAL;
                end else if (n_used == '0 || nb_used == '0) begin
                  pend_band <= NO_FLAP;
                  state     <= S_FINAL;
                end else begin
                  state <= S_FIRST;
                end
              end
              FUNC_LIST: begin
                if (n_used != '0 && nb_used != '0) begin
                  state <= S_FIRST;
                end
              end
            endcase
          end
        end
        S_FIRST: begin
          if (mass_q <= cur16) begin
            slot_a <= '0;
            slot_b <= '0;
            frac   <= '0;
            state  <= S_RA;
          end else begin
            state <= S_LASTW;
          end
        end
        S_LASTW: begin
          if (mass_q >= cur16) begin
            slot_a <= WAW'(n_used - NW'(1));
            slot_b <= WAW'(n_used - NW'(1));
            frac   <= '0;
            state  <= S_RA;
          end else begin
            j     <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          prev_w <= w_rd;
          if (scan_hit) begin
            slot_a <= j - WAW'(1);
            slot_b <= j;
            if (span == '0) begin
              frac  <= '0;
              state <= S_RA;
            end else begin
              state <= S_DIV;
            end
          end else if (NW'(j) == n_used - NW'(1)) begin
            slot_a <= '0;
            slot_b <= '0;
            frac   <= '0;
            state  <= S_RA;
          end else begin
            j <= j + WAW'(1);
          end
        end
        S_DIV: begin
          if (!div_busy) begin
            frac  <= div_frac;
            state <= S_RA;
          end
        end
        S_RA: state <= S_RB;
        S_RB: begin
          c1    <= r_rd;
          state <= S_EVAL;
        end
        S_EVAL: begin
          c2 <= r_rd;
          if (!(c1.present && r_rd.present)) begin
            state <= S_NEXT;
          end else if (c1_span && c2_span) begin
            prod  <= $signed({1'b0, frac}) * mul_diff;
            state <= S_LERP1;
          end else if (c1_span) begin
            cur_lo <= c1.vmin;
            cur_hi <= c1.vmax;
            state  <= S_CHECK;
          end else if (c2_span) begin
            cur_lo <= r_rd.vmin;
            cur_hi <= r_rd.vmax;
            state  <= S_CHECK;
          end else begin
            cur_lo <= NO_SPEED;
            cur_hi <= NO_SPEED;
            state  <= S_CHECK;
          end
        end
        S_LERP1: begin
          cur_lo <= c1.vmin + lerp_adj;
          prod   <= $signed({1'b0, frac}) * mul_diff;
          state  <= S_LERP2;
        end
        S_LERP2: begin
          cur_hi <= c1.vmax + lerp_adj;
          state  <= S_CHECK;
        end
        S_CHECK: begin
          if (func_q == FUNC_BEST) begin
            if (in_range) begin
              pend_band <= FLAP_W'(bi);
              state     <= S_FINAL;
            end else begin
              state <= S_NEXT;
            end
          end else if (!have_pend) begin
            pend_band <= FLAP_W'(bi);
            pend_lo   <= cur_lo;
            pend_hi   <= cur_hi;
            have_pend <= 1'b1;
            state     <= S_NEXT;
          end else if (out_free) begin
            // previous band goes out, this one waits for a successor
            band_index <= pend_band;
            range_min  <= pend_lo;
            range_max  <= pend_hi;
            last       <= 1'b0;
            pend_band  <= FLAP_W'(bi);
            pend_lo    <= cur_lo;
            pend_hi    <= cur_hi;
            state      <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (bi == nb_used - NBW'(1)) begin
            if (func_q == FUNC_BEST) begin
              pend_band <= NO_FLAP;
              state     <= S_FINAL;
            end else if (have_pend) begin
              state <= S_FINAL;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            bi    <= bi + NBW'(1);
            state <= S_RA;
          end
        end
        S_FINAL: begin
          if (out_free) begin
            band_index <= pend_band;
            range_min  <= pend_lo;
            range_max  <= pend_hi;
            last       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "flap_band_select_by_mass_speed_defines.svh"

  `FBS_CHECK(a_band_in_range, state == S_RA, bi < nb_used)
  `FBS_CHECK(a_bracket_order, state == S_RA, slot_a <= slot_b)
  `FBS_CHECK(a_frac_bound, state == S_RA, frac <= 17'h10000)
  `FBS_CHECK_NEXT(a_final_last, state == S_FINAL && !rsp_valid, rsp_valid && last)

endmodule
`default_nettype wire
